[src/bufifo_pkg.sv]
// Shared types and constants for the bounded unique FIFO.
`timescale 1ns / 1ps

package bufifo_pkg;

    // Fixed field widths of the result and configuration ports
    localparam int CNT_W  = 5;
    localparam int PICK_W = 16;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_DUP   = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        FUNC_PUT  = 1'b0,
        FUNC_PICK = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PICK,
        S_SCAN
    } state_t;

endpackage

[src/bounded_unique_fifo.sv]
// Top level of the bounded FIFO of identifiers with duplicate rejection.
`timescale 1ns / 1ps

// Usage:
//  Input channel (in_valid / in_stall): func selects put (append item_id at
//  the tail) or pick (remove the head). One transfer starts one operation.
//  Output channel (out_valid / out_stall): exactly one result per input
//  transfer: status, picked_id (head on a good pick, else 0) and occupancy
//  after the operation.
//  Configuration: cfg_we / cfg_wdata write the capacity register (reset 16);
//  the effective capacity is the smaller of capacity and DEPTH.
//  Timing, from input transfer edge to result loaded in the output register:
//   - put refused full, pick on empty: same edge;
//   - pick, put into an empty queue: the next edge (one read or one write);
//   - put into a non-empty queue: set by the duplicate scan, which reads
//     one stored identifier per cycle from the single read port of the
//     slot memory, then writes the tail on the last compare cycle.
//  One operation is in flight at a time; the next transfer is taken
//  only after the result has loaded.
//  Reset clears head, tail, count, the state machine and the output valid;
//  slot contents are not cleared, since only held entries are ever read.
//  While the receiver stalls, the result holds and no new input is taken.
module bounded_unique_fifo #(
    parameter int DEPTH   = 16,
    parameter int ID_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_we,
    input  logic [bufifo_pkg::CNT_W-1:0]  cfg_wdata,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          func,
    input  logic [ID_BITS-1:0]            item_id,
    // output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [bufifo_pkg::PICK_W-1:0] picked_id,
    output logic [bufifo_pkg::CNT_W-1:0]  occupancy
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = bufifo_pkg::CNT_W;
    // count can never exceed the 5-bit capacity nor DEPTH
    localparam logic [CW-1:0] DEPTH_CAP = CW'((DEPTH > 31) ? 31 : DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    // slot memory, one write and one registered read port
    logic [ID_BITS-1:0] mem [DEPTH];
    logic [ID_BITS-1:0] rd_data_reg;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;

    // control state
    bufifo_pkg::state_t state_reg, state_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [AW-1:0]      tail_reg, tail_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      scan_ptr_reg, scan_ptr_next;
    logic [CW-1:0]      left_reg, left_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [CW-1:0]      cap_reg;

    // operation being worked on
    logic [ID_BITS-1:0] id_reg, id_next;

    // output register
    logic                          out_valid_reg, out_valid_next;
    logic [1:0]                    status_reg, status_next;
    logic [bufifo_pkg::PICK_W-1:0] picked_reg, picked_next;
    logic [CW-1:0]                 occ_reg, occ_next;

    logic          out_free;
    logic          in_xfer;
    logic [CW-1:0] cap_eff;
    logic          match;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == bufifo_pkg::S_IDLE) && out_free);
    assign in_xfer  = in_valid && !in_stall;
    assign cap_eff  = (cap_reg < DEPTH_CAP) ? cap_reg : DEPTH_CAP;
    assign match    = rd_vld_reg && (rd_data_reg == id_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CW'(16);
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[tail_reg] <= id_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bufifo_pkg::S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            scan_ptr_reg  <= '0;
            left_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            scan_ptr_reg  <= scan_ptr_next;
            left_reg      <= left_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        id_reg     <= id_next;
        status_reg <= status_next;
        picked_reg <= picked_next;
        occ_reg    <= occ_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        scan_ptr_next  = scan_ptr_reg;
        left_next      = left_reg;
        rd_vld_next    = 1'b0;
        id_next        = id_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        picked_next    = picked_reg;
        occ_next       = occ_reg;
        rd_en          = 1'b0;
        rd_addr        = head_reg;
        wr_en          = 1'b0;

        case (state_reg)
            bufifo_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    id_next = item_id;
                    if (func == bufifo_pkg::FUNC_PICK)
                    begin
                        if (count_reg == '0)
                        begin
                            out_valid_next = 1'b1;
                            status_next    = bufifo_pkg::ST_EMPTY;
                            picked_next    = '0;
                            occ_next       = count_reg;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            state_next = bufifo_pkg::S_PICK;
                        end
                    end
                    else if (count_reg >= cap_eff)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = bufifo_pkg::ST_FULL;
                        picked_next    = '0;
                        occ_next       = count_reg;
                    end
                    else if (count_reg == '0)
                    begin
                        // nothing to compare against: the scan state writes without a read
                        left_next  = '0;
                        state_next = bufifo_pkg::S_SCAN;
                    end
                    else
                    begin
                        // first scan read at head
                        rd_en         = 1'b1;
                        rd_vld_next   = 1'b1;
                        scan_ptr_next = wrap_inc(head_reg);
                        left_next     = count_reg - 1'b1;
                        state_next    = bufifo_pkg::S_SCAN;
                    end
                end
            end

            bufifo_pkg::S_PICK:
            begin
                head_next      = wrap_inc(head_reg);
                count_next     = count_reg - 1'b1;
                out_valid_next = 1'b1;
                status_next    = bufifo_pkg::ST_OK;
                picked_next    = bufifo_pkg::PICK_W'(rd_data_reg);
                occ_next       = count_reg - 1'b1;
                state_next     = bufifo_pkg::S_IDLE;
            end

            bufifo_pkg::S_SCAN:
            begin
                if (match)
                begin
                    out_valid_next = 1'b1;
                    status_next    = bufifo_pkg::ST_DUP;
                    picked_next    = '0;
                    occ_next       = count_reg;
                    state_next     = bufifo_pkg::S_IDLE;
                end
                else if (left_reg != '0)
                begin
                    // keep one read in flight while comparing the last
                    rd_en         = 1'b1;
                    rd_addr       = scan_ptr_reg;
                    rd_vld_next   = 1'b1;
                    scan_ptr_next = wrap_inc(scan_ptr_reg);
                    left_next     = left_reg - 1'b1;
                end
                else
                begin
                    // last compare clean: append at tail
                    wr_en          = 1'b1;
                    tail_next      = wrap_inc(tail_reg);
                    count_next     = count_reg + 1'b1;
                    out_valid_next = 1'b1;
                    status_next    = bufifo_pkg::ST_OK;
                    picked_next    = '0;
                    occ_next       = count_reg + 1'b1;
                    state_next     = bufifo_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = bufifo_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign picked_id = picked_reg;
    assign occupancy = occ_reg;

endmodule

[src/bufifo_chk.sv]
// Port-level checker for the bounded unique FIFO, with its bind.
`timescale 1ns / 1ps

module bufifo_chk #(
    parameter int DEPTH   = 16,
    parameter int ID_BITS = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          func,
    input logic [ID_BITS-1:0]            item_id,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [1:0]                    status,
    input logic [bufifo_pkg::PICK_W-1:0] picked_id,
    input logic [bufifo_pkg::CNT_W-1:0]  occupancy
);

    localparam int OCC_MAX = (DEPTH > 31) ? 31 : DEPTH;

    // stalled input offer holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable({func, item_id}))
        else $error("input offer changed while stalled");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable({status, picked_id, occupancy}))
        else $error("result changed while stalled");

    // refusals carry no identifier
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == bufifo_pkg::ST_FULL || status == bufifo_pkg::ST_DUP
                      || status == bufifo_pkg::ST_EMPTY) |-> picked_id == '0)
        else $error("picked_id nonzero on refused operation");

    // empty pick reports empty queue
    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == bufifo_pkg::ST_EMPTY |-> occupancy == '0)
        else $error("empty pick with nonzero occupancy");

    // occupancy bounded by storage
    a_occ_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(occupancy) <= OCC_MAX)
        else $error("occupancy above depth");

endmodule

bind bounded_unique_fifo bufifo_chk #(.DEPTH(DEPTH), .ID_BITS(ID_BITS)) u_bufifo_chk (.*);

[verif/tb_bounded_unique_fifo.sv]
// Self-checking testbench for the bounded FIFO of identifiers with duplicate rejection.
`timescale 1ns / 1ps

module tb_bounded_unique_fifo;

    localparam int DEPTH   = 16;
    localparam int ID_BITS = 16;
    localparam int CNT_W   = bufifo_pkg::CNT_W;
    localparam int PICK_W  = bufifo_pkg::PICK_W;
    // Worst case per item is set by the gap, the scan and the stall; this
    // limit is several times that for the whole run.
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 110;

    // One entry of the stimulus queue: either an operation or a capacity write
    typedef struct {
        bit                 is_cap;
        bufifo_pkg::func_t  op;
        logic [ID_BITS-1:0] id;
        logic [CNT_W-1:0]   cap;
    } queue_req_t;

    typedef struct {
        bufifo_pkg::status_t status;
        logic [PICK_W-1:0]   picked;
        logic [CNT_W-1:0]    occ;
    } queue_reply_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CNT_W-1:0]     cfg_wdata = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 func = 1'b0;
    logic [ID_BITS-1:0]   item_id = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           status;
    logic [PICK_W-1:0]    picked_id;
    logic [CNT_W-1:0]     occupancy;

    bounded_unique_fifo #(
        .DEPTH   (DEPTH),
        .ID_BITS (ID_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .item_id   (item_id),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .picked_id (picked_id),
        .occupancy (occupancy)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the queue: ring of identifiers, head and count,
    // plus the capacity register as last written.
    // ------------------------------------------------------------------
    logic [ID_BITS-1:0] shadow_slots [DEPTH];
    logic [3:0]         shadow_head = '0;
    logic [CNT_W-1:0]   shadow_count = '0;
    logic [CNT_W-1:0]   shadow_cap = 5'd16;

    queue_req_t   op_queue[$];
    queue_reply_t predicted_results[$];

    int err_count = 0;
    int cap_writes = 0;
    int status_seen [4] = '{0, 0, 0, 0};
    int cycle_cnt = 0;

    // Applies one operation to the shadow queue and returns the reply the
    // block must give for it.
    function automatic queue_reply_t predict_queue_op(bufifo_pkg::func_t op,
                                                      logic [ID_BITS-1:0] id);
        queue_reply_t r;
        logic [CNT_W-1:0] lim;
        logic [3:0] pos;
        logic hit;
        int k;
        r.status = bufifo_pkg::ST_OK;
        r.picked = '0;
        // capacity above the ring size is clipped to the ring size
        lim = (shadow_cap > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : shadow_cap;
        if (op == bufifo_pkg::FUNC_PUT)
        begin
            hit = 1'b0;
            for (k = 0; k < int'(shadow_count); k++)
            begin
                pos = shadow_head + 4'(k);
                if (shadow_slots[pos] == id)
                    hit = 1'b1;
            end
            // full wins over duplicate
            if (shadow_count >= lim)
                r.status = bufifo_pkg::ST_FULL;
            else if (hit)
                r.status = bufifo_pkg::ST_DUP;
            else
            begin
                pos = shadow_head + 4'(shadow_count);
                shadow_slots[pos] = id;
                shadow_count = shadow_count + 1'b1;
            end
        end
        else
        begin
            if (shadow_count == 0)
                r.status = bufifo_pkg::ST_EMPTY;
            else
            begin
                r.picked = shadow_slots[shadow_head];
                shadow_head = shadow_head + 1'b1;
                shadow_count = shadow_count - 1'b1;
            end
        end
        r.occ = shadow_count;
        return r;
    endfunction

    // Wait length for the next transfer, drawn at random, with occasional runs of
    // back-to-back transfers.
    function automatic int draw_wait(inout int burst_left);
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
            burst_left = $urandom_range(8, 40);
        return $urandom_range(0, 9);
    endfunction

    task automatic push_op(bufifo_pkg::func_t op, logic [ID_BITS-1:0] id);
        queue_req_t e;
        e.is_cap = 1'b0;
        e.op = op;
        e.id = id;
        e.cap = '0;
        op_queue.push_back(e);
    endtask

    task automatic push_cap(logic [CNT_W-1:0] value);
        queue_req_t e;
        e.is_cap = 1'b1;
        e.op = bufifo_pkg::FUNC_PUT;
        e.id = '0;
        e.cap = value;
        op_queue.push_back(e);
    endtask

    // ------------------------------------------------------------------
    // Driver: presents queued operations on the input channel and holds
    // each payload until its transfer. Capacity writes wait until every
    // predicted reply has been seen, so the block is idle.
    // ------------------------------------------------------------------
    int drv_gap = 0;
    int drv_burst = 0;

    always @(posedge clk)
    begin
        logic nxt_valid;
        logic nxt_we;
        queue_reply_t r;
        if (rst_n)
        begin
            nxt_valid = in_valid;
            nxt_we = 1'b0;
            if (in_valid && !in_stall)
            begin
                r = predict_queue_op(bufifo_pkg::func_t'(func), item_id);
                predicted_results.push_back(r);
                void'(op_queue.pop_front());
                nxt_valid = 1'b0;
                drv_gap = draw_wait(drv_burst);
            end
            if (!nxt_valid)
            begin
                if (drv_gap != 0)
                    drv_gap--;
                else if (op_queue.size() != 0)
                begin
                    if (op_queue[0].is_cap)
                    begin
                        if (predicted_results.size() == 0 && !cfg_we)
                        begin
                            nxt_we = 1'b1;
                            cfg_wdata <= op_queue[0].cap;
                            shadow_cap = op_queue[0].cap;
                            cap_writes++;
                            void'(op_queue.pop_front());
                        end
                    end
                    else
                    begin
                        nxt_valid = 1'b1;
                        func <= op_queue[0].op;
                        item_id <= op_queue[0].id;
                    end
                end
            end
            in_valid <= nxt_valid;
            cfg_we <= nxt_we;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each reply transfer against the oldest prediction
    // and stalls the output channel at random between transfers.
    // ------------------------------------------------------------------
    int mon_stall = 0;
    int mon_burst = 0;

    always @(posedge clk)
    begin
        queue_reply_t r;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (predicted_results.size() == 0)
                begin
                    $error("reply transfer with nothing predicted: status %0d picked %0h occ %0d",
                           status, picked_id, occupancy);
                    err_count++;
                end
                else
                begin
                    r = predicted_results.pop_front();
                    status_seen[r.status]++;
                    if (status !== r.status)
                    begin
                        $error("status: expected %0d, actual %0d", r.status, status);
                        err_count++;
                    end
                    if (picked_id !== r.picked)
                    begin
                        $error("picked_id: expected %0h, actual %0h", r.picked, picked_id);
                        err_count++;
                    end
                    if (occupancy !== r.occ)
                    begin
                        $error("occupancy: expected %0d, actual %0d", r.occ, occupancy);
                        err_count++;
                    end
                end
                mon_stall = draw_wait(mon_burst);
            end
            if (mon_stall != 0)
            begin
                mon_stall--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    int phase_caps [10] = '{31, 16, 0, 1, 5, 16, 17, 2, 0, 15};
    int phase_puts [10] = '{80, 50, 50, 60, 70, 40, 85, 55, 0, 65};

    initial
    begin
        logic [ID_BITS-1:0] id_pool [24];
        logic [ID_BITS-1:0] id;
        bufifo_pkg::func_t op;
        int ph;
        int n;
        int put_pct;

        // Directed: empty pick, extreme identifiers, duplicates at head and tail
        push_op(bufifo_pkg::FUNC_PICK, 16'h1234);
        push_op(bufifo_pkg::FUNC_PUT, 16'h0000);
        push_op(bufifo_pkg::FUNC_PUT, 16'hFFFF);
        push_op(bufifo_pkg::FUNC_PUT, 16'hFFFF);
        push_op(bufifo_pkg::FUNC_PUT, 16'h0000);
        push_op(bufifo_pkg::FUNC_PICK, 16'hFFFF);
        push_op(bufifo_pkg::FUNC_PICK, 16'h0000);
        push_op(bufifo_pkg::FUNC_PICK, 16'h5555);
        // capacity zero refuses every put
        push_cap(5'd0);
        push_op(bufifo_pkg::FUNC_PUT, 16'hA5A5);
        push_op(bufifo_pkg::FUNC_PICK, 16'h0000);
        // small capacity: full and duplicate together reports full
        push_cap(5'd2);
        push_op(bufifo_pkg::FUNC_PUT, 16'h0001);
        push_op(bufifo_pkg::FUNC_PUT, 16'h0001);
        push_op(bufifo_pkg::FUNC_PUT, 16'h8000);
        push_op(bufifo_pkg::FUNC_PUT, 16'h0001);
        push_op(bufifo_pkg::FUNC_PICK, 16'h0000);
        push_op(bufifo_pkg::FUNC_PUT, 16'h7FFF);
        push_op(bufifo_pkg::FUNC_PICK, 16'h0000);
        push_op(bufifo_pkg::FUNC_PICK, 16'h0000);

        // Random phases. Most identifiers come from a small pool so that
        // duplicates and full queues are common; the rest are unconstrained.
        for (ph = 0; ph < 10; ph++)
        begin
            push_cap(ph == 8 ? CNT_W'($urandom_range(0, 31)) : CNT_W'(phase_caps[ph]));
            put_pct = (ph == 8) ? $urandom_range(30, 80) : phase_puts[ph];
            foreach (id_pool[i])
                id_pool[i] = ID_BITS'($urandom);
            id_pool[0] = '0;
            id_pool[1] = '1;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                op = ($urandom_range(0, 99) < put_pct) ? bufifo_pkg::FUNC_PUT
                                                       : bufifo_pkg::FUNC_PICK;
                if ($urandom_range(0, 9) < 7)
                    id = id_pool[$urandom_range(0, 23)];
                else
                    id = ID_BITS'($urandom);
                push_op(op, id);
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (op_queue.size() != 0 || in_valid || predicted_results.size() != 0)
            @(posedge clk);
        // any stray reply would show up here
        repeat (DEPTH + 8) @(posedge clk);

        $display("replies checked: %0d ok, %0d full, %0d duplicate, %0d empty",
                 status_seen[bufifo_pkg::ST_OK], status_seen[bufifo_pkg::ST_FULL],
                 status_seen[bufifo_pkg::ST_DUP], status_seen[bufifo_pkg::ST_EMPTY]);
        $display("capacity writes: %0d, mismatches: %0d", cap_writes, err_count);
        if (err_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
